// ===== hdl/kus2_pkg.sv =====
package kus2_pkg;

	localparam logic [7:0] CODE_BREAK     = 8'hF0;
	localparam logic [7:0] CODE_EXTEND    = 8'hE0;
	localparam logic [7:0] CODE_PAUSE_PFX = 8'hE1;
	localparam logic [7:0] CODE_PRTSC_A   = 8'h12;
	localparam logic [7:0] CODE_PRTSC_B   = 8'h7C;
	localparam logic [7:0] CODE_PAUSE_A   = 8'h14;
	localparam logic [7:0] CODE_PAUSE_B   = 8'h77;

	localparam logic [7:0] USAGE_PRTSC = 8'h46;
	localparam logic [7:0] USAGE_PAUSE = 8'h48;

	typedef logic [2:0] step_t;
	typedef logic [8:0] map_entry_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_PLAIN,
		KIND_PRTSC,
		KIND_PAUSE
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} seq_beat_t;

	function automatic map_entry_t usage_map(input logic [7:0] usage);
		map_entry_t e;
		e = 9'h000;
		unique case (usage)
			8'd4: e = 9'h01C;   8'd5: e = 9'h032;   8'd6: e = 9'h021;   8'd7: e = 9'h023;
			8'd8: e = 9'h024;   8'd9: e = 9'h02B;   8'd10: e = 9'h034;  8'd11: e = 9'h033;
			8'd12: e = 9'h043;  8'd13: e = 9'h03B;  8'd14: e = 9'h042;  8'd15: e = 9'h04B;
			8'd16: e = 9'h03A;  8'd17: e = 9'h031;  8'd18: e = 9'h044;  8'd19: e = 9'h04D;
			8'd20: e = 9'h015;  8'd21: e = 9'h02D;  8'd22: e = 9'h01B;  8'd23: e = 9'h02C;
			8'd24: e = 9'h03C;  8'd25: e = 9'h02A;  8'd26: e = 9'h01D;  8'd27: e = 9'h022;
			8'd28: e = 9'h035;  8'd29: e = 9'h01A;  8'd30: e = 9'h016;  8'd31: e = 9'h01E;
			8'd32: e = 9'h026;  8'd33: e = 9'h025;  8'd34: e = 9'h02E;  8'd35: e = 9'h036;
			8'd36: e = 9'h03D;  8'd37: e = 9'h03E;  8'd38: e = 9'h046;  8'd39: e = 9'h045;
			8'd40: e = 9'h05A;  8'd41: e = 9'h076;  8'd42: e = 9'h066;  8'd43: e = 9'h00D;
			8'd44: e = 9'h029;  8'd45: e = 9'h04E;  8'd46: e = 9'h055;  8'd47: e = 9'h054;
			8'd48: e = 9'h05B;  8'd49: e = 9'h05D;  8'd51: e = 9'h04C;  8'd52: e = 9'h052;
			8'd53: e = 9'h00E;  8'd54: e = 9'h041;  8'd55: e = 9'h049;  8'd56: e = 9'h04A;
			8'd57: e = 9'h058;  8'd58: e = 9'h005;  8'd59: e = 9'h006;  8'd60: e = 9'h004;
			8'd61: e = 9'h00C;  8'd62: e = 9'h003;  8'd63: e = 9'h00B;  8'd64: e = 9'h083;
			8'd65: e = 9'h00A;  8'd66: e = 9'h001;  8'd67: e = 9'h009;  8'd68: e = 9'h078;
			8'd69: e = 9'h007;  8'd71: e = 9'h07E;
			8'd73: e = 9'h170;  8'd74: e = 9'h16C;  8'd75: e = 9'h17D;  8'd76: e = 9'h171;
			8'd77: e = 9'h169;  8'd78: e = 9'h17A;  8'd79: e = 9'h174;  8'd80: e = 9'h16B;
			8'd81: e = 9'h172;  8'd82: e = 9'h175;
			8'd83: e = 9'h077;  8'd84: e = 9'h14A;  8'd85: e = 9'h07C;  8'd86: e = 9'h07B;
			8'd87: e = 9'h079;  8'd88: e = 9'h15A;
			8'd89: e = 9'h069;  8'd90: e = 9'h072;  8'd91: e = 9'h07A;  8'd92: e = 9'h06B;
			8'd93: e = 9'h073;  8'd94: e = 9'h074;  8'd95: e = 9'h06C;  8'd96: e = 9'h075;
			8'd97: e = 9'h07D;  8'd98: e = 9'h070;  8'd99: e = 9'h071;  8'd101: e = 9'h12F;
			8'd224: e = 9'h014; 8'd225: e = 9'h012; 8'd226: e = 9'h011; 8'd227: e = 9'h11F;
			8'd228: e = 9'h114; 8'd229: e = 9'h059; 8'd230: e = 9'h111; 8'd231: e = 9'h127;
			default: e = 9'h000;
		endcase
		return e;
	endfunction

	function automatic seq_beat_t seq_beat(input kind_t kind, input logic ext, input logic rel,
			input logic [7:0] code, input step_t step);
		seq_beat_t b;
		b.data = 8'h00;
		b.last = 1'b0;
		unique case (kind)
			KIND_PLAIN: begin
				if (ext && step == 3'd0) begin
					b.data = CODE_EXTEND;
				end else if (rel && step == {2'b00, ext}) begin
					b.data = CODE_BREAK;
				end else begin
					b.data = code;
				end
				b.last = (step == ({2'b00, ext} + {2'b00, rel}));
			end
			KIND_PRTSC: begin
				if (!rel) begin
					unique case (step)
						3'd0: b.data = CODE_EXTEND;
						3'd1: b.data = CODE_PRTSC_A;
						3'd2: b.data = CODE_EXTEND;
						3'd3: begin
							b.data = CODE_PRTSC_B;
							b.last = 1'b1;
						end
						default: b.data = CODE_EXTEND;
					endcase
				end else begin
					unique case (step)
						3'd0: b.data = CODE_EXTEND;
						3'd1: b.data = CODE_BREAK;
						3'd2: b.data = CODE_PRTSC_B;
						3'd3: b.data = CODE_EXTEND;
						3'd4: b.data = CODE_BREAK;
						3'd5: begin
							b.data = CODE_PRTSC_A;
							b.last = 1'b1;
						end
						default: b.data = CODE_EXTEND;
					endcase
				end
			end
			KIND_PAUSE: begin
				if (!rel) begin
					unique case (step)
						3'd0: b.data = CODE_PAUSE_PFX;
						3'd1: b.data = CODE_PAUSE_A;
						3'd2: b.data = CODE_PAUSE_B;
						3'd3: b.data = CODE_PAUSE_A;
						3'd4: begin
							b.data = CODE_PAUSE_B;
							b.last = 1'b1;
						end
						default: b.data = CODE_PAUSE_PFX;
					endcase
				end else begin
					unique case (step)
						3'd0: b.data = CODE_PAUSE_PFX;
						3'd1: b.data = CODE_PAUSE_A;
						3'd2: b.data = CODE_BREAK;
						3'd3: b.data = CODE_PAUSE_B;
						3'd4: b.data = CODE_PAUSE_A;
						3'd5: b.data = CODE_BREAK;
						3'd6: begin
							b.data = CODE_PAUSE_B;
							b.last = 1'b1;
						end
						default: b.data = CODE_PAUSE_PFX;
					endcase
				end
			end
			KIND_NONE: begin
				b.data = 8'h00;
				b.last = 1'b1;
			end
			default: begin
				b.data = 8'h00;
				b.last = 1'b1;
			end
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/kus2_rom.sv =====
module kus2_rom (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [7:0]               rd_addr,
	output kus2_pkg::map_entry_t     rd_data
);

	kus2_pkg::map_entry_t rom_q [256];
	kus2_pkg::map_entry_t rd_data_q;

	always_comb begin
		for (int i = 0; i < 256; i++) begin
			rom_q[i] = kus2_pkg::usage_map(8'(i));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= rom_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/key_usage_to_ps2_set2_codes.sv =====
// channel  | handshake            | payload
// ---------+----------------------+------------------------------
// in       | in_valid / in_ready  | key_usage[7:0], key_release
// out      | out_valid / out_ready| code_byte[7:0], last_byte
//
// One code byte per cycle unless out_ready stalls; an event of 1 to 7 bytes holds the byte sequencer.
// First byte passes the table read at the input beat, then the sequencer, then the output register.
// A new event is taken while the previous one is still being sent; unlisted keys are dropped unsent.
// Reset clears all valid flags; the usage table is a constant ROM and needs no clearing.
// A stalled output holds the sequencer, which in turn holds the input stage.
module key_usage_to_ps2_set2_codes (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] key_usage,
	input  logic       key_release,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] code_byte,
	output logic       last_byte
);

	logic                  valid_s1;
	logic [7:0]            usage_s1;
	logic                  rel_s1;
	kus2_pkg::map_entry_t  entry_s1;
	kus2_pkg::kind_t       kind_s1;

	logic                  seq_valid_q;
	kus2_pkg::kind_t       seq_kind_q;
	logic                  seq_ext_q;
	logic                  seq_rel_q;
	logic [7:0]            seq_code_q;
	kus2_pkg::step_t       seq_step_q;
	kus2_pkg::seq_beat_t   cur;

	logic                  out_valid_q;
	logic [7:0]            code_byte_q;
	logic                  last_byte_q;

	logic in_fire;
	logic out_load;
	logic seq_fire;
	logic seq_done;
	logic seq_free;
	logic s1_drop;
	logic seq_load;
	logic s1_move;

	kus2_rom u_rom (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (key_usage),
		.rd_data (entry_s1)
	);

	always_comb begin
		if (usage_s1 == kus2_pkg::USAGE_PRTSC) begin
			kind_s1 = kus2_pkg::KIND_PRTSC;
		end else if (usage_s1 == kus2_pkg::USAGE_PAUSE) begin
			kind_s1 = kus2_pkg::KIND_PAUSE;
		end else if (entry_s1 != 9'h000) begin
			kind_s1 = kus2_pkg::KIND_PLAIN;
		end else begin
			kind_s1 = kus2_pkg::KIND_NONE;
		end
	end

	assign cur      = kus2_pkg::seq_beat(seq_kind_q, seq_ext_q, seq_rel_q, seq_code_q, seq_step_q);
	assign out_load = !out_valid_q || out_ready;
	assign seq_fire = seq_valid_q && out_load;
	assign seq_done = seq_fire && cur.last;
	assign seq_free = !seq_valid_q || seq_done;
	assign s1_drop  = valid_s1 && (kind_s1 == kus2_pkg::KIND_NONE);
	assign seq_load = valid_s1 && (kind_s1 != kus2_pkg::KIND_NONE) && seq_free;
	assign s1_move  = s1_drop || seq_load;
	assign in_ready = !valid_s1 || s1_move;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			usage_s1 <= key_usage;
			rel_s1   <= key_release;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_valid_q <= 1'b0;
			seq_step_q  <= '0;
		end else if (seq_load) begin
			seq_valid_q <= 1'b1;
			seq_step_q  <= '0;
		end else if (seq_done) begin
			seq_valid_q <= 1'b0;
		end else if (seq_fire) begin
			seq_step_q <= seq_step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_load) begin
			seq_kind_q <= kind_s1;
			seq_ext_q  <= entry_s1[8];
			seq_rel_q  <= rel_s1;
			seq_code_q <= entry_s1[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= seq_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_fire) begin
			code_byte_q <= cur.data;
			last_byte_q <= cur.last;
		end
	end

	assign out_valid = out_valid_q;
	assign code_byte = code_byte_q;
	assign last_byte = last_byte_q;

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		seq_load |=> seq_valid_q && seq_step_q == 3'd0)
		else $error("sequencer load did not restart at first byte");

	a_step_advance: assert property (@(posedge clk) disable iff (!arst_n)
		seq_fire && !cur.last |=> seq_valid_q && seq_step_q == $past(seq_step_q) + 3'd1)
		else $error("sequencer step did not advance");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid_q |-> seq_step_q <= 3'd6)
		else $error("sequencer ran past the longest sequence");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done && !seq_load |=> !seq_valid_q)
		else $error("sequencer still busy after last byte");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         HOLD_CYCLES = 20;
	localparam int         STALL_LIMIT = 2000;
	localparam int         KEYS_PER_PHASE = 95;
	localparam int         DIR_ROWS = 24;
	localparam logic [3:0] ROW_PREDICT = 4'hF;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} scan_byte_t;

	typedef struct packed {
		logic [7:0]  usage;
		logic        rel;
		logic [3:0]  n;
		logic [55:0] seq;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] key_usage = 8'h00;
	logic       key_release = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] code_byte;
	logic       last_byte;

	scan_byte_t scan_bytes_due [$];
	logic [8:0] scan_tab [256];
	dir_row_t   dir_rows [DIR_ROWS];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;

	key_usage_to_ps2_set2_codes u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_usage  (key_usage),
		.key_release(key_release),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_byte  (code_byte),
		.last_byte  (last_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (scan_tab[i]) scan_tab[i] = 9'h000;
		scan_tab[4] = 9'h01C;   scan_tab[5] = 9'h032;   scan_tab[6] = 9'h021;
		scan_tab[7] = 9'h023;   scan_tab[8] = 9'h024;   scan_tab[9] = 9'h02B;
		scan_tab[10] = 9'h034;  scan_tab[11] = 9'h033;  scan_tab[12] = 9'h043;
		scan_tab[13] = 9'h03B;  scan_tab[14] = 9'h042;  scan_tab[15] = 9'h04B;
		scan_tab[16] = 9'h03A;  scan_tab[17] = 9'h031;  scan_tab[18] = 9'h044;
		scan_tab[19] = 9'h04D;  scan_tab[20] = 9'h015;  scan_tab[21] = 9'h02D;
		scan_tab[22] = 9'h01B;  scan_tab[23] = 9'h02C;  scan_tab[24] = 9'h03C;
		scan_tab[25] = 9'h02A;  scan_tab[26] = 9'h01D;  scan_tab[27] = 9'h022;
		scan_tab[28] = 9'h035;  scan_tab[29] = 9'h01A;  scan_tab[30] = 9'h016;
		scan_tab[31] = 9'h01E;  scan_tab[32] = 9'h026;  scan_tab[33] = 9'h025;
		scan_tab[34] = 9'h02E;  scan_tab[35] = 9'h036;  scan_tab[36] = 9'h03D;
		scan_tab[37] = 9'h03E;  scan_tab[38] = 9'h046;  scan_tab[39] = 9'h045;
		scan_tab[40] = 9'h05A;  scan_tab[41] = 9'h076;  scan_tab[42] = 9'h066;
		scan_tab[43] = 9'h00D;  scan_tab[44] = 9'h029;  scan_tab[45] = 9'h04E;
		scan_tab[46] = 9'h055;  scan_tab[47] = 9'h054;  scan_tab[48] = 9'h05B;
		scan_tab[49] = 9'h05D;  scan_tab[51] = 9'h04C;  scan_tab[52] = 9'h052;
		scan_tab[53] = 9'h00E;  scan_tab[54] = 9'h041;  scan_tab[55] = 9'h049;
		scan_tab[56] = 9'h04A;  scan_tab[57] = 9'h058;  scan_tab[58] = 9'h005;
		scan_tab[59] = 9'h006;  scan_tab[60] = 9'h004;  scan_tab[61] = 9'h00C;
		scan_tab[62] = 9'h003;  scan_tab[63] = 9'h00B;  scan_tab[64] = 9'h083;
		scan_tab[65] = 9'h00A;  scan_tab[66] = 9'h001;  scan_tab[67] = 9'h009;
		scan_tab[68] = 9'h078;  scan_tab[69] = 9'h007;  scan_tab[71] = 9'h07E;
		scan_tab[73] = 9'h170;  scan_tab[74] = 9'h16C;  scan_tab[75] = 9'h17D;
		scan_tab[76] = 9'h171;  scan_tab[77] = 9'h169;  scan_tab[78] = 9'h17A;
		scan_tab[79] = 9'h174;  scan_tab[80] = 9'h16B;  scan_tab[81] = 9'h172;
		scan_tab[82] = 9'h175;  scan_tab[83] = 9'h077;  scan_tab[84] = 9'h14A;
		scan_tab[85] = 9'h07C;  scan_tab[86] = 9'h07B;  scan_tab[87] = 9'h079;
		scan_tab[88] = 9'h15A;  scan_tab[89] = 9'h069;  scan_tab[90] = 9'h072;
		scan_tab[91] = 9'h07A;  scan_tab[92] = 9'h06B;  scan_tab[93] = 9'h073;
		scan_tab[94] = 9'h074;  scan_tab[95] = 9'h06C;  scan_tab[96] = 9'h075;
		scan_tab[97] = 9'h07D;  scan_tab[98] = 9'h070;  scan_tab[99] = 9'h071;
		scan_tab[101] = 9'h12F; scan_tab[224] = 9'h014; scan_tab[225] = 9'h012;
		scan_tab[226] = 9'h011; scan_tab[227] = 9'h11F; scan_tab[228] = 9'h114;
		scan_tab[229] = 9'h059; scan_tab[230] = 9'h111; scan_tab[231] = 9'h127;
	end

	function automatic int push_scan_sequence(input logic [7:0] usage, input logic rel);
		logic [7:0] seq [$];
		logic [8:0] ent;
		ent = scan_tab[usage];
		if (usage == kus2_pkg::USAGE_PRTSC) begin
			seq.push_back(kus2_pkg::CODE_EXTEND);
			if (rel) begin
				seq.push_back(kus2_pkg::CODE_BREAK);
				seq.push_back(kus2_pkg::CODE_PRTSC_B);
				seq.push_back(kus2_pkg::CODE_EXTEND);
				seq.push_back(kus2_pkg::CODE_BREAK);
				seq.push_back(kus2_pkg::CODE_PRTSC_A);
			end else begin
				seq.push_back(kus2_pkg::CODE_PRTSC_A);
				seq.push_back(kus2_pkg::CODE_EXTEND);
				seq.push_back(kus2_pkg::CODE_PRTSC_B);
			end
		end else if (usage == kus2_pkg::USAGE_PAUSE) begin
			seq.push_back(kus2_pkg::CODE_PAUSE_PFX);
			for (int k = 0; k < 2; k++) begin
				seq.push_back(kus2_pkg::CODE_PAUSE_A);
				if (rel) seq.push_back(kus2_pkg::CODE_BREAK);
				seq.push_back(kus2_pkg::CODE_PAUSE_B);
			end
		end else if (ent != 9'h000) begin
			if (ent[8]) seq.push_back(kus2_pkg::CODE_EXTEND);
			if (rel) seq.push_back(kus2_pkg::CODE_BREAK);
			seq.push_back(ent[7:0]);
		end
		foreach (seq[i]) scan_bytes_due.push_back('{code: seq[i], last: (i == seq.size() - 1)});
		return seq.size();
	endfunction

	task automatic send_key(input logic [7:0] usage, input logic rel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		key_usage   <= usage;
		key_release <= rel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		scan_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (scan_bytes_due.size() == 0) begin
				$display("%0t: unexpected byte %02h last %0b", $time, code_byte, last_byte);
				mismatches++;
			end else begin
				want = scan_bytes_due.pop_front();
				if (code_byte !== want.code) begin
					$display("%0t: code_byte expected %02h, got %02h", $time, want.code, code_byte);
					mismatches++;
				end
				if (last_byte !== want.last) begin
					$display("%0t: last_byte expected %0b, got %0b", $time, want.last, last_byte);
					mismatches++;
				end
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] usage;
		logic       rel;
		int         pick;
		int         listed;
		int         n_bytes;
		dir_rows[0]  = '{8'h00, 1'b0, 4'd0, 56'h0};
		dir_rows[1]  = '{8'hFF, 1'b1, 4'd0, 56'h0};
		dir_rows[2]  = '{8'h04, 1'b0, 4'd1, 56'h1C000000000000};
		dir_rows[3]  = '{8'h04, 1'b1, ROW_PREDICT, 56'h0};
		dir_rows[4]  = '{kus2_pkg::USAGE_PRTSC, 1'b0, 4'd4, 56'hE012E07C000000};
		dir_rows[5]  = '{kus2_pkg::USAGE_PRTSC, 1'b1, 4'd6, 56'hE0F07CE0F01200};
		dir_rows[6]  = '{kus2_pkg::USAGE_PAUSE, 1'b0, 4'd5, 56'hE1147714770000};
		dir_rows[7]  = '{kus2_pkg::USAGE_PAUSE, 1'b1, 4'd7, 56'hE114F07714F077};
		dir_rows[8]  = '{8'hE7, 1'b1, 4'd3, 56'hE0F02700000000};
		dir_rows[9]  = '{8'hE7, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[10] = '{8'h49, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[11] = '{8'h52, 1'b1, ROW_PREDICT, 56'h0};
		dir_rows[12] = '{8'h40, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[13] = '{8'h40, 1'b1, ROW_PREDICT, 56'h0};
		dir_rows[14] = '{8'h65, 1'b1, ROW_PREDICT, 56'h0};
		dir_rows[15] = '{8'h66, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[16] = '{8'hDF, 1'b1, ROW_PREDICT, 56'h0};
		dir_rows[17] = '{8'hE8, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[18] = '{8'h32, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[19] = '{8'hE0, 1'b1, ROW_PREDICT, 56'h0};
		dir_rows[20] = '{8'h58, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[21] = '{8'h28, 1'b1, ROW_PREDICT, 56'h0};
		dir_rows[22] = '{8'h63, 1'b0, ROW_PREDICT, 56'h0};
		dir_rows[23] = '{8'h80, 1'b0, ROW_PREDICT, 56'h0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_key(dir_rows[r].usage, dir_rows[r].rel);
			if (dir_rows[r].n == ROW_PREDICT) begin
				void'(push_scan_sequence(dir_rows[r].usage, dir_rows[r].rel));
			end else begin
				for (int i = 0; i < dir_rows[r].n; i++) begin
					scan_bytes_due.push_back('{code: dir_rows[r].seq[55 - 8 * i -: 8],
						last: (i == dir_rows[r].n - 1)});
				end
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			listed = 0;
			while (listed < KEYS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					usage = $urandom_range(1) ? kus2_pkg::USAGE_PRTSC : kus2_pkg::USAGE_PAUSE;
				end else if (pick < 23) begin
					usage = 8'($urandom_range(255));
				end else begin
					do begin
						usage = ($urandom_range(9) == 0) ? 8'($urandom_range(231, 224))
							: 8'($urandom_range(101, 4));
					end while (scan_tab[usage] == 9'h000);
				end
				rel = 1'($urandom_range(1));
				send_key(usage, rel);
				n_bytes = push_scan_sequence(usage, rel);
				if (n_bytes != 0) listed++;
				if (listed == KEYS_PER_PHASE / 2 && n_bytes != 0) begin
					// hold off until the output side has drained
					in_valid <= 1'b0;
					do @(posedge clk); while (scan_bytes_due.size() != 0);
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (scan_bytes_due.size() != 0);
		repeat (HOLD_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
